// ===== rtl/core/ttte_pkg.sv =====
// Shared types and constants for the Toffoli truth table engine.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ttte_pkg;

   // Default sizing handed to the top-level parameters
   localparam int DEF_MAX_LINES = 8;
   localparam int DEF_MAX_GATES = 256;

   // Field widths fixed by the stream format
   localparam int MASK_W      = 8;
   localparam int CMD_W       = 3;
   localparam int LINE_CNT_W  = 4;
   localparam int CNT_OUT_W   = 9;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   localparam logic [LINE_CNT_W-1:0] LINE_COUNT_RESET = 4'd8;

   typedef enum logic [CMD_W-1:0] {
      OP_APPEND       = 3'd0,
      OP_REMOVE_LAST  = 3'd1,
      OP_PREPEND      = 3'd2,
      OP_REMOVE_FIRST = 3'd3,
      OP_COMPARE      = 3'd4
   } ttte_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } ttte_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_GATE_WAIT,
      S_XOR_FILL,
      S_XOR_RUN,
      S_XOR_DRAIN,
      S_SWAP_SCAN,
      S_SWAP_WA,
      S_SWAP_WB,
      S_CMP_RD,
      S_CMP_CHK,
      S_FINISH
   } ttte_state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic add_tail;
      logic add_head;
      logic take_tail;
      logic take_head;
      logic gate_load;
      logic set_full;
      logic set_empty;
      logic scan_clear;
      logic scan_step;
      logic xor_issue;
      logic xor_write;
      logic swap_issue;
      logic swap_write_a;
      logic swap_write_b;
      logic cmp_issue;
      logic cmp_check;
      logic rsp_load;
   } ttte_cmd_type;

   // Datapath to controller
   typedef struct packed {
      ttte_op_type op;
      logic        last;
      logic        full;
      logic        empty;
      logic        scan_last;
      logic        swap_hit;
      logic        cmp_in_range;
      logic        out_free;
   } ttte_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/ttte_ctrl.sv =====
// Sequencing state machine of the Toffoli truth table engine.
// Uses ttte_pkg; drives the command struct of ttte_dpath.
`default_nettype none

module ttte_ctrl
   import ttte_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire ttte_stat_type stat,
   output ttte_cmd_type       cmd
);

   ttte_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (stat.op)
               OP_APPEND:       state_in = stat.full  ? S_FINISH : S_XOR_FILL;
               OP_PREPEND:      state_in = stat.full  ? S_FINISH : S_SWAP_SCAN;
               OP_REMOVE_LAST:  state_in = stat.empty ? S_FINISH : S_GATE_WAIT;
               OP_REMOVE_FIRST: state_in = stat.empty ? S_FINISH : S_GATE_WAIT;
               OP_COMPARE:      state_in = S_CMP_RD;
               default:         state_in = S_IDLE;
            endcase
         end
         S_GATE_WAIT: begin
            state_in = (stat.op == OP_REMOVE_LAST) ? S_XOR_FILL : S_SWAP_SCAN;
         end
         S_XOR_FILL: begin
            state_in = stat.scan_last ? S_XOR_DRAIN : S_XOR_RUN;
         end
         S_XOR_RUN: begin
            state_in = stat.scan_last ? S_XOR_DRAIN : S_XOR_RUN;
         end
         S_XOR_DRAIN: begin
            state_in = S_FINISH;
         end
         S_SWAP_SCAN: begin
            if (stat.swap_hit) state_in = S_SWAP_WA;
            else if (stat.scan_last) state_in = S_FINISH;
         end
         S_SWAP_WA: begin
            state_in = S_SWAP_WB;
         end
         S_SWAP_WB: begin
            state_in = stat.scan_last ? S_FINISH : S_SWAP_SCAN;
         end
         S_CMP_RD: begin
            if (stat.cmp_in_range) state_in = S_CMP_CHK;
            else state_in = stat.last ? S_FINISH : S_IDLE;
         end
         S_CMP_CHK: begin
            state_in = stat.last ? S_FINISH : S_IDLE;
         end
         S_FINISH: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_DECODE: begin
            unique case (stat.op)
               OP_APPEND: begin
                  cmd.set_full   = stat.full;
                  cmd.add_tail   = !stat.full;
                  cmd.scan_clear = 1'b1;
               end
               OP_PREPEND: begin
                  cmd.set_full   = stat.full;
                  cmd.add_head   = !stat.full;
                  cmd.scan_clear = 1'b1;
               end
               OP_REMOVE_LAST: begin
                  cmd.set_empty = stat.empty;
                  cmd.take_tail = !stat.empty;
               end
               OP_REMOVE_FIRST: begin
                  cmd.set_empty = stat.empty;
                  cmd.take_head = !stat.empty;
               end
               default: begin
               end
            endcase
         end
         S_GATE_WAIT: begin
            cmd.gate_load  = 1'b1;
            cmd.scan_clear = 1'b1;
         end
         S_XOR_FILL: begin
            cmd.xor_issue = 1'b1;
         end
         S_XOR_RUN: begin
            cmd.xor_issue = 1'b1;
            cmd.xor_write = 1'b1;
         end
         S_XOR_DRAIN: begin
            cmd.xor_write = 1'b1;
         end
         S_SWAP_SCAN: begin
            cmd.swap_issue = stat.swap_hit;
            cmd.scan_step  = !stat.swap_hit && !stat.scan_last;
         end
         S_SWAP_WA: begin
            cmd.swap_write_a = 1'b1;
         end
         S_SWAP_WB: begin
            cmd.swap_write_b = 1'b1;
            cmd.scan_step    = !stat.scan_last;
         end
         S_CMP_RD: begin
            cmd.cmp_issue = stat.cmp_in_range;
         end
         S_CMP_CHK: begin
            cmd.cmp_check = 1'b1;
         end
         S_FINISH: begin
            cmd.rsp_load = stat.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/ttte_dpath.sv =====
// Datapath of the Toffoli truth table engine: table memory with valid bits,
// gate ring store, compare counters and result register. Uses ttte_pkg.
`default_nettype none

module ttte_dpath
   import ttte_pkg::*;
#(
   parameter int MAX_LINES = DEF_MAX_LINES,
   parameter int MAX_GATES = DEF_MAX_GATES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [CMD_W-1:0]       req_tuser,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tlast,
   input  wire logic                   csr_valid,
   input  wire logic [LINE_CNT_W-1:0]  csr_data,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [STATUS_W-1:0]         rsp_tuser,
   input  wire ttte_cmd_type           cmd,
   output ttte_stat_type               stat
);

   localparam int ROW_W   = MAX_LINES;
   localparam int ROW_CNT = 1 << MAX_LINES;
   localparam int IDX_W   = MAX_LINES + 1;
   localparam int GAW     = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
   localparam int CW      = $clog2(MAX_GATES + 1);

   // Latched operation
   ttte_op_type        op_ff;
   logic [ROW_W-1:0]   op_t_ff;
   logic [ROW_W-1:0]   op_c_ff;
   logic [MASK_W-1:0]  op_ref_ff;
   logic               op_last_ff;
   ttte_status_type    res_status_ff;
   logic [ROW_W-1:0]   gate_t_q, gate_c_q;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= ttte_op_type'(req_tuser);
         op_t_ff    <= req_tdata[ROW_W-1:0];
         op_c_ff    <= req_tdata[MASK_W +: ROW_W];
         op_ref_ff  <= req_tdata[2*MASK_W +: MASK_W];
         op_last_ff <= req_tlast;
      end else if (cmd.gate_load) begin
         op_t_ff    <= gate_t_q;
         op_c_ff    <= gate_c_q;
      end
      if (cmd.capture) res_status_ff <= STATUS_DONE;
      else if (cmd.set_full) res_status_ff <= STATUS_FULL;
      else if (cmd.set_empty) res_status_ff <= STATUS_EMPTY;
   end

   // Configuration register
   logic [LINE_CNT_W-1:0] line_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= LINE_COUNT_RESET;
      end else if (csr_valid) begin
         line_count_ff <= csr_data;
      end
   end

   // Gate ring store
   logic [GAW-1:0]   head_ff, head_in;
   logic [CW-1:0]    held_ff, held_in;
   logic [CW:0]      tail_sum, tail_wrap, back_sum, back_wrap;
   logic [GAW-1:0]   head_dec, head_inc, gate_wr_addr, gate_rd_addr;
   logic [ROW_W-1:0] gate_t_mem [MAX_GATES];
   logic [ROW_W-1:0] gate_c_mem [MAX_GATES];

   always_comb begin
      tail_sum  = (CW+1)'(head_ff) + (CW+1)'(held_ff);
      tail_wrap = (tail_sum >= (CW+1)'(MAX_GATES)) ? tail_sum - (CW+1)'(MAX_GATES) : tail_sum;
      back_sum  = tail_sum - (CW+1)'(1);
      back_wrap = (back_sum >= (CW+1)'(MAX_GATES)) ? back_sum - (CW+1)'(MAX_GATES) : back_sum;
      head_dec  = (head_ff == '0) ? GAW'(MAX_GATES - 1) : head_ff - GAW'(1);
      head_inc  = (head_ff == GAW'(MAX_GATES - 1)) ? '0 : head_ff + GAW'(1);
      gate_wr_addr = cmd.add_head ? head_dec : GAW'(tail_wrap);
      gate_rd_addr = cmd.take_head ? head_ff : GAW'(back_wrap);
      head_in = head_ff;
      held_in = held_ff;
      if (cmd.add_head) head_in = head_dec;
      if (cmd.take_head) head_in = head_inc;
      if (cmd.add_tail || cmd.add_head) held_in = held_ff + CW'(1);
      if (cmd.take_tail || cmd.take_head) held_in = held_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         held_ff <= '0;
      end else begin
         head_ff <= head_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_tail || cmd.add_head) begin
         gate_t_mem[gate_wr_addr] <= op_t_ff;
         gate_c_mem[gate_wr_addr] <= op_c_ff;
      end
      if (cmd.take_tail || cmd.take_head) begin
         gate_t_q <= gate_t_mem[gate_rd_addr];
         gate_c_q <= gate_c_mem[gate_rd_addr];
      end
   end

   // Row scan counter
   logic [ROW_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan_clear) cnt_ff <= '0;
      else if (cmd.scan_step || cmd.xor_issue) cnt_ff <= cnt_ff + ROW_W'(1);
   end

   // Compare counters
   logic [IDX_W-1:0]      cmp_idx_ff, mism_ff;
   logic [LINE_CNT_W-1:0] lines_sat;
   logic [IDX_W-1:0]      cmp_range;

   // Table memory, two registered read ports, one write port
   logic [ROW_W-1:0] row_mem [ROW_CNT];
   logic             row_vld_ff [ROW_CNT];
   logic [ROW_W-1:0] rd_addr_a, rd_addr_b;
   logic [ROW_W-1:0] addr_a_ff, addr_b_ff;
   logic [ROW_W-1:0] q_a, q_b;
   logic             vld_a_ff, vld_b_ff;
   logic [ROW_W-1:0] row_a, row_b;
   logic             rd_en;
   logic             wr_en;
   logic [ROW_W-1:0] wr_addr, wr_data;

   always_comb begin
      rd_addr_a = cmd.cmp_issue ? cmp_idx_ff[ROW_W-1:0] : cnt_ff;
      rd_addr_b = cnt_ff ^ op_t_ff;
      rd_en     = cmd.xor_issue || cmd.swap_issue || cmd.cmp_issue;
      // An entry never written still holds the identity value
      row_a = vld_a_ff ? q_a : addr_a_ff;
      row_b = vld_b_ff ? q_b : addr_b_ff;
      wr_en   = cmd.xor_write || cmd.swap_write_a || cmd.swap_write_b;
      wr_addr = cmd.swap_write_b ? addr_b_ff : addr_a_ff;
      if (cmd.swap_write_a) wr_data = row_b;
      else if (cmd.swap_write_b) wr_data = row_a;
      else if ((row_a & op_c_ff) == op_c_ff) wr_data = row_a ^ op_t_ff;
      else wr_data = row_a;
   end

   always_ff @(posedge clock) begin
      if (wr_en) row_mem[wr_addr] <= wr_data;
      if (rd_en) begin
         q_a       <= row_mem[rd_addr_a];
         q_b       <= row_mem[rd_addr_b];
         vld_a_ff  <= row_vld_ff[rd_addr_a];
         vld_b_ff  <= row_vld_ff[rd_addr_b];
         addr_a_ff <= rd_addr_a;
         addr_b_ff <= rd_addr_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROW_CNT; i++) row_vld_ff[i] <= 1'b0;
      end else if (wr_en) begin
         row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      lines_sat = (line_count_ff > LINE_CNT_W'(MAX_LINES)) ? LINE_CNT_W'(MAX_LINES)
                                                          : line_count_ff;
      cmp_range = IDX_W'(1) << lines_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_idx_ff <= '0;
         mism_ff    <= '0;
      end else if (cmd.rsp_load && op_ff == OP_COMPARE) begin
         cmp_idx_ff <= '0;
         mism_ff    <= '0;
      end else if (cmd.cmp_check) begin
         cmp_idx_ff <= cmp_idx_ff + IDX_W'(1);
         if (MASK_W'(row_a) != op_ref_ff) mism_ff <= mism_ff + IDX_W'(1);
      end
   end

   // Result register
   logic                 rsp_valid_ff;
   ttte_status_type      rsp_status_ff;
   logic [CNT_OUT_W-1:0] rsp_count_ff, rsp_mism_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= CNT_OUT_W'(held_ff);
         rsp_mism_ff   <= (op_ff == OP_COMPARE) ? CNT_OUT_W'(mism_ff) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 2*CNT_OUT_W){1'b0}}, rsp_mism_ff, rsp_count_ff};

   // Status to controller
   always_comb begin
      stat.op           = op_ff;
      stat.last         = op_last_ff;
      stat.full         = (held_ff == CW'(MAX_GATES));
      stat.empty        = (held_ff == '0);
      stat.scan_last    = &cnt_ff;
      stat.swap_hit     = ((cnt_ff & op_c_ff) == op_c_ff) &&
                          ((cnt_ff & op_t_ff) == op_t_ff) && (op_t_ff != '0);
      stat.cmp_in_range = (cmp_idx_ff < cmp_range);
      stat.out_free     = !rsp_valid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

// ===== rtl/core/toffoli_truth_table_engine_core.sv =====
// Top level of the Toffoli truth table engine: controller plus datapath.
// Uses ttte_pkg, ttte_ctrl and ttte_dpath.
//
// The engine holds the truth table of a reversible circuit (2^MAX_LINES rows,
// identity after reset) and a double-ended list of up to MAX_GATES gates.
// One request transaction carries one command in req_tuser. Append and
// remove-last XOR the gate's target into every row holding all control bits;
// this is a pipelined read-modify-write sweep of the table memory (a remove
// first fetches the gate from the ring store). Prepend and remove-first swap
// row pairs; the single write port of the table memory writes each swapped
// pair in two steps, one row at a time. A compare row reads its table row
// only inside the compare range, then checks it; a last row also returns a
// response. A blocked response register holds back every transaction that
// ends in a response. Each gate command and each row marked last return one
// response transaction; other compare rows and unused command codes return
// none. The block takes one request at a time; a finished response waits in
// an output register while the next request is accepted. Per-row valid bits
// restore the identity table at reset, so no clearing pass follows reset.
// line_count is to be written through the csr port only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module toffoli_truth_table_engine_core
   import ttte_pkg::*;
#(
   parameter int MAX_LINES = DEF_MAX_LINES,
   parameter int MAX_GATES = DEF_MAX_GATES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // gate target, gate control, ref_row
   input  wire logic [CMD_W-1:0]       req_tuser,  // cmd
   input  wire logic                   req_tlast,  // last_row
   // Response stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,  // gate_count, mismatches, zero pad
   output logic [STATUS_W-1:0]         rsp_tuser,  // status
   // Configuration write
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [LINE_CNT_W-1:0]  csr_data    // line_count
);

   ttte_cmd_type  cmd;
   ttte_stat_type stat;

   // Writes are taken at once; software writes only while idle
   assign csr_ready = 1'b1;

   ttte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ttte_dpath #(
      .MAX_LINES (MAX_LINES),
      .MAX_GATES (MAX_GATES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ttte_checker.sv =====
// Port-level assertions for the Toffoli truth table engine, bound to the top.
// Uses ttte_pkg and toffoli_truth_table_engine_core.
`default_nettype none

module ttte_checker
   import ttte_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [STATUS_W-1:0]    rsp_tuser
);

   // No response survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // The engine is busy in the cycle after it accepts a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // An empty report holds no gates
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |-> rsp_tdata[8:0] == '0)
      else $error("empty status with nonzero gate count");

   // Refused gate commands carry no mismatch count and pad stays zero
   a_refused_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_DONE |-> rsp_tdata[RSP_TDATA_W-1:9] == '0)
      else $error("refused command reports mismatches");

endmodule

bind toffoli_truth_table_engine_core ttte_checker u_checker (.*);

`default_nettype wire
